// File: hw/rtl/box_average_downscaler_assert.svh
// ----------------------------------------------------------------------------
// Box average downscaler assertion macros
// Concurrent assertion shorthands shared by the downscaler RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bad_pkg.sv
// ----------------------------------------------------------------------------
// Box average downscaler package
// Shared widths, register indexes, beat types and reciprocal tables.
// ----------------------------------------------------------------------------
package bad_pkg;

    localparam int LANES      = 4;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int SCALE_W    = 5;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 12;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;
    localparam int M_PAD_W    = M_DATA_W - LANES * PIX_W - OUT_COL_W - OUT_ROW_W;
    localparam int CMP_W      = 15;

    localparam int AREA_W           = 9;
    localparam int RECIP_AREA_W     = 25;
    localparam int RECIP_AREA_SHIFT = 24;
    localparam int RECIP_N_W        = 17;
    localparam int RECIP_N_SHIFT    = 16;

    localparam int RC_CNT_W      = 2;
    localparam int RECALC_CYCLES = 3;

    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = 3;
    localparam int FIFO_CNT_W   = 4;
    localparam int PIPE_STAGES  = 3;
    localparam int ACCEPT_LIMIT = FIFO_DEPTH - PIPE_STAGES;

    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FOUR   = 2'd3;

    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 5'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef logic [LANES-1:0][PIX_W-1:0] lane_pix_t;
    typedef logic [LANES-1:0][SUM_W-1:0] lane_sums_t;

    typedef struct packed {
        logic                 four;
        logic                 frame_done;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_column;
    } beat_meta_t;

    typedef struct packed {
        beat_meta_t meta;
        lane_pix_t  avg;
    } out_beat_t;

    // floor(2^24 / (n * n)), indexed by n - 1.
    function automatic logic [RECIP_AREA_W-1:0] recip_area_lut(input logic [3:0] idx);
        logic [RECIP_AREA_W-1:0] r;
        unique case (idx)
            4'd0:  r = 25'd16777216;
            4'd1:  r = 25'd4194304;
            4'd2:  r = 25'd1864135;
            4'd3:  r = 25'd1048576;
            4'd4:  r = 25'd671088;
            4'd5:  r = 25'd466033;
            4'd6:  r = 25'd342392;
            4'd7:  r = 25'd262144;
            4'd8:  r = 25'd207126;
            4'd9:  r = 25'd167772;
            4'd10: r = 25'd138654;
            4'd11: r = 25'd116508;
            4'd12: r = 25'd99273;
            4'd13: r = 25'd85598;
            4'd14: r = 25'd74565;
            4'd15: r = 25'd65536;
        endcase
        return r;
    endfunction

    // floor(2^16 / n), indexed by n - 1.
    function automatic logic [RECIP_N_W-1:0] recip_scale_lut(input logic [3:0] idx);
        logic [RECIP_N_W-1:0] r;
        unique case (idx)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd32768;
            4'd2:  r = 17'd21845;
            4'd3:  r = 17'd16384;
            4'd4:  r = 17'd13107;
            4'd5:  r = 17'd10922;
            4'd6:  r = 17'd9362;
            4'd7:  r = 17'd8192;
            4'd8:  r = 17'd7281;
            4'd9:  r = 17'd6553;
            4'd10: r = 17'd5957;
            4'd11: r = 17'd5461;
            4'd12: r = 17'd5041;
            4'd13: r = 17'd4681;
            4'd14: r = 17'd4369;
            4'd15: r = 17'd4096;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/bad_avg_div.sv
// ----------------------------------------------------------------------------
// Block average divider
// Divides four lane sums by the block area through a reciprocal multiply,
// a back multiply and a single correction step; two register stages.
// ----------------------------------------------------------------------------
module bad_avg_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  bad_pkg::lane_sums_t             in_sums,
    input  bad_pkg::beat_meta_t             in_meta,
    input  logic [bad_pkg::AREA_W-1:0]      area,
    input  logic [bad_pkg::RECIP_AREA_W-1:0] recip,
    output logic                            out_valid,
    output bad_pkg::lane_pix_t              out_avg,
    output bad_pkg::beat_meta_t             out_meta
);
    import bad_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_AREA_W;
    localparam int BACK_W = SUM_W + AREA_W;

    logic                           a_valid_reg;
    lane_sums_t                     a_sums_reg;
    logic [LANES-1:0][PROD_W-1:0]   a_prod_reg;
    beat_meta_t                     a_meta_reg;
    lane_sums_t                     a_quot;

    logic                           b_valid_reg;
    lane_sums_t                     b_sums_reg;
    lane_sums_t                     b_quot_reg;
    lane_sums_t                     b_back_reg;
    beat_meta_t                     b_meta_reg;

    lane_sums_t                     rem;
    lane_sums_t                     quot_fix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            a_quot[k] = SUM_W'(a_prod_reg[k] >> RECIP_AREA_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < LANES; k++) begin
            a_prod_reg[k] <= PROD_W'(in_sums[k]) * PROD_W'(recip);
            b_back_reg[k] <= SUM_W'(BACK_W'(a_quot[k]) * BACK_W'(area));
        end
        a_sums_reg <= in_sums;
        a_meta_reg <= in_meta;
        b_sums_reg <= a_sums_reg;
        b_quot_reg <= a_quot;
        b_meta_reg <= a_meta_reg;
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rem[k]      = b_sums_reg[k] - b_back_reg[k];
            quot_fix[k] = b_quot_reg[k] + SUM_W'(rem[k] >= SUM_W'(area));
            if (quot_fix[k] > SUM_W'(255)) begin
                out_avg[k] = 8'hFF;
            end else begin
                out_avg[k] = quot_fix[k][PIX_W-1:0];
            end
        end
        if (!b_meta_reg.four) begin
            out_avg[LANES-1] = '0;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_meta  = b_meta_reg;

endmodule

// File: hw/rtl/box_average_downscaler.sv
// ----------------------------------------------------------------------------
// Box average downscaler
// Shrinks a raster pixel stream by N in both directions, averaging each
// N by N block per channel with a line store of per-column sums.
// ----------------------------------------------------------------------------
// Source pixels enter on the s_ channel in raster order, one pixel per beat.
// Each beat reads the column sum of its block column from a line memory with
// one read and one write port, adds the pixel in the next cycle and writes it
// back; a beat that hits the entry being written in that cycle takes the
// written value directly. The bottom right pixel of a block sends the four sums
// through a two-stage reciprocal divider into an eight-entry output queue.
// Throughput is one pixel per cycle while the m_ side keeps up and no
// recalculation runs. A result passes the accumulate stage, both divider
// stages and the queue before it is ready on m_. When the receiver stalls,
// the queue absorbs the pixels in flight and s_tready drops once five results
// wait. Each configuration write, and reset, starts a recalculation of the
// output size and the current block row, during which s_tready is low. Reset
// clears the position counters and the queue; the line memory is not cleared,
// since every block overwrites its entry on its first pixel.
// ----------------------------------------------------------------------------
`include "box_average_downscaler_assert.svh"

module box_average_downscaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_SCALE  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // chan_zero, chan_one, chan_two, chan_three
    input  logic [bad_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // avg_zero, avg_one, avg_two, avg_three, out_column, out_row, zero padding
    output logic [bad_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [bad_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bad_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import bad_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int SUB_W     = $clog2(MAX_SCALE);
    localparam int RC_X_W    = 14;
    localparam int RC_PROD_W = RC_X_W + RECIP_N_W;
    localparam int RC_NUM    = 3;
    localparam int RC_IDX_W  = 0;
    localparam int RC_IDX_H  = 1;
    localparam int RC_IDX_R  = 2;

    logic [SCALE_W-1:0]    scale_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic                  four_reg;

    logic [SCALE_W-1:0]    n_c;
    logic [WIDTH_W-1:0]    w_c;
    logic [HEIGHT_W-1:0]   h_c;
    logic [3:0]            n_idx;

    logic [RC_CNT_W-1:0]   rc_cnt_reg;
    logic                  rc_busy;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_x;
    logic [RC_NUM-1:0][RC_PROD_W-1:0] rc_prod_reg;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_quot;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_quot_reg;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_back_reg;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_rem;
    logic [RC_NUM-1:0]                rc_fix;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_q_fin;
    logic [RC_NUM-1:0][RC_X_W-1:0]    rc_r_fin;

    logic [WIDTH_W-1:0]      out_w_reg;
    logic [HEIGHT_W-1:0]     out_h_reg;
    logic [AREA_W-1:0]       area_reg;
    logic [RECIP_AREA_W-1:0] recip_area_reg;

    logic [COL_W-1:0]      pcol_reg;
    logic [ROW_W-1:0]      prow_reg;
    logic [SUB_W-1:0]      subc_reg;
    logic [SUB_W-1:0]      subr_reg;
    logic [COL_W-1:0]      bcol_reg;
    logic [ROW_W-1:0]      brow_reg;
    logic [SUB_W-1:0]      phase_reg;

    logic                  s_accept;
    logic                  col_end;
    logic                  row_end;
    logic                  frame_end;
    logic                  subr_end;
    logic                  phase_end;
    logic                  blk_ok;
    logic                  emit;
    logic                  fresh;
    logic                  last_blk;
    lane_pix_t             in_px;

    logic                  p1_valid_reg;
    logic                  p1_write_reg;
    logic                  p1_emit_reg;
    logic                  p1_fresh_reg;
    logic [COL_W-1:0]      p1_addr_reg;
    lane_pix_t             p1_px_reg;
    beat_meta_t            p1_meta_reg;

    lane_sums_t            sum_mem [MAX_WIDTH];
    lane_sums_t            rd_data_reg;
    lane_sums_t            base;
    lane_sums_t            s1_next;
    logic                  s1_we;
    logic                  fwd_valid_reg;
    lane_sums_t            fwd_data_reg;

    logic                  div_valid;
    lane_pix_t             div_avg;
    beat_meta_t            div_meta;

    out_beat_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic                  m_pop;
    out_beat_t             head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            four_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SCALE:  scale_reg  <= cfg_wr_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                REG_FOUR:   four_reg   <= cfg_wr_data[0];
            endcase
        end
    end

    always_comb begin
        priority if (scale_reg == '0) begin
            n_c = SCALE_W'(1);
        end else if (CMP_W'(scale_reg) > CMP_W'(MAX_SCALE)) begin
            n_c = SCALE_W'(MAX_SCALE);
        end else begin
            n_c = scale_reg;
        end
        priority if (width_reg == '0) begin
            w_c = WIDTH_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_c = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_c = width_reg;
        end
        priority if (height_reg == '0) begin
            h_c = HEIGHT_W'(1);
        end else if (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) begin
            h_c = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_c = height_reg;
        end
        n_idx = 4'(n_c - SCALE_W'(1));
    end

    // Recalculation of width/N, height/N and row/N after reset or a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_cnt_reg <= RC_CNT_W'(RECALC_CYCLES);
        end else if (cfg_wr_en) begin
            rc_cnt_reg <= RC_CNT_W'(RECALC_CYCLES);
        end else if (rc_busy) begin
            rc_cnt_reg <= rc_cnt_reg - RC_CNT_W'(1);
        end
    end

    assign rc_busy = (rc_cnt_reg != '0);

    always_comb begin
        rc_x[RC_IDX_W] = RC_X_W'(w_c);
        rc_x[RC_IDX_H] = RC_X_W'(h_c);
        rc_x[RC_IDX_R] = RC_X_W'(prow_reg);
        for (int i = 0; i < RC_NUM; i++) begin
            rc_quot[i]  = RC_X_W'(rc_prod_reg[i] >> RECIP_N_SHIFT);
            rc_rem[i]   = rc_x[i] - rc_back_reg[i];
            rc_fix[i]   = (rc_rem[i] >= RC_X_W'(n_c));
            rc_q_fin[i] = rc_quot_reg[i] + RC_X_W'(rc_fix[i]);
            rc_r_fin[i] = rc_fix[i] ? rc_rem[i] - RC_X_W'(n_c) : rc_rem[i];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RC_NUM; i++) begin
            rc_prod_reg[i] <= RC_PROD_W'(rc_x[i]) * RC_PROD_W'(recip_scale_lut(n_idx));
            rc_quot_reg[i] <= rc_quot[i];
            rc_back_reg[i] <= RC_X_W'(RC_PROD_W'(rc_quot[i]) * RC_PROD_W'(n_c));
        end
        if (rc_busy) begin
            out_w_reg      <= WIDTH_W'(rc_q_fin[RC_IDX_W]);
            out_h_reg      <= HEIGHT_W'(rc_q_fin[RC_IDX_H]);
            area_reg       <= AREA_W'(AREA_W'(n_c) * AREA_W'(n_c));
            recip_area_reg <= recip_area_lut(n_idx);
        end
    end

    // Position tracking at the input.
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !rc_busy && (fifo_count_reg < FIFO_CNT_W'(ACCEPT_LIMIT));

    always_comb begin
        col_end   = (CMP_W'(subc_reg) + CMP_W'(1)) >= CMP_W'(n_c);
        row_end   = (CMP_W'(pcol_reg) + CMP_W'(1)) >= CMP_W'(w_c);
        frame_end = (CMP_W'(prow_reg) + CMP_W'(1)) >= CMP_W'(h_c);
        subr_end  = (CMP_W'(subr_reg) + CMP_W'(1)) >= CMP_W'(n_c);
        phase_end = (CMP_W'(phase_reg) + CMP_W'(1)) >= CMP_W'(n_c);
        blk_ok    = (CMP_W'(bcol_reg) < CMP_W'(out_w_reg))
                 && (CMP_W'(brow_reg) < CMP_W'(out_h_reg));
        emit      = blk_ok && col_end && subr_end;
        fresh     = (subr_reg == '0) && (subc_reg == '0);
        last_blk  = ((CMP_W'(bcol_reg) + CMP_W'(1)) == CMP_W'(out_w_reg))
                 && ((CMP_W'(brow_reg) + CMP_W'(1)) == CMP_W'(out_h_reg));
        in_px     = s_tdata;
        if (!four_reg) begin
            in_px[LANES-1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg  <= '0;
            prow_reg  <= '0;
            subc_reg  <= '0;
            subr_reg  <= '0;
            bcol_reg  <= '0;
            brow_reg  <= '0;
            phase_reg <= '0;
        end else if (rc_busy) begin
            brow_reg  <= ROW_W'(rc_q_fin[RC_IDX_R]);
            phase_reg <= SUB_W'(rc_r_fin[RC_IDX_R]);
        end else if (s_accept) begin
            if (row_end) begin
                pcol_reg <= '0;
                subc_reg <= '0;
                bcol_reg <= '0;
                if (frame_end) begin
                    prow_reg  <= '0;
                    subr_reg  <= '0;
                    brow_reg  <= '0;
                    phase_reg <= '0;
                end else begin
                    prow_reg <= prow_reg + ROW_W'(1);
                    subr_reg <= subr_end ? '0 : subr_reg + SUB_W'(1);
                    if (phase_end) begin
                        phase_reg <= '0;
                        brow_reg  <= brow_reg + ROW_W'(1);
                    end else begin
                        phase_reg <= phase_reg + SUB_W'(1);
                    end
                end
            end else begin
                pcol_reg <= pcol_reg + COL_W'(1);
                if (col_end) begin
                    subc_reg <= '0;
                    bcol_reg <= bcol_reg + COL_W'(1);
                end else begin
                    subc_reg <= subc_reg + SUB_W'(1);
                end
            end
        end
    end

    // Read stage: the line memory is read at the block column of each beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_write_reg           <= blk_ok;
            p1_emit_reg            <= emit;
            p1_fresh_reg           <= fresh;
            p1_addr_reg            <= bcol_reg;
            p1_px_reg              <= in_px;
            p1_meta_reg.four       <= four_reg;
            p1_meta_reg.frame_done <= last_blk;
            p1_meta_reg.out_row    <= OUT_ROW_W'(brow_reg);
            p1_meta_reg.out_column <= OUT_COL_W'(bcol_reg);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= sum_mem[bcol_reg];
    end

    // Accumulate stage: add the pixel and write the sums back.
    always_comb begin
        priority if (p1_fresh_reg) begin
            base = '0;
        end else if (fwd_valid_reg) begin
            base = fwd_data_reg;
        end else begin
            base = rd_data_reg;
        end
        for (int k = 0; k < LANES; k++) begin
            s1_next[k] = base[k] + SUM_W'(p1_px_reg[k]);
        end
    end

    assign s1_we = p1_valid_reg && p1_write_reg;

    always_ff @(posedge aclk) begin
        if (s1_we) begin
            sum_mem[p1_addr_reg] <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= s1_we && s_accept && (bcol_reg == p1_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= s1_next;
    end

    bad_avg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p1_valid_reg && p1_emit_reg),
        .in_sums   (s1_next),
        .in_meta   (p1_meta_reg),
        .area      (area_reg),
        .recip     (recip_area_reg),
        .out_valid (div_valid),
        .out_avg   (div_avg),
        .out_meta  (div_meta)
    );

    // Output queue.
    assign m_pop    = m_tvalid && m_tready;
    assign m_tvalid = (fifo_count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (div_valid) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (div_valid && !m_pop) begin
                fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(1);
            end else if (m_pop && !div_valid) begin
                fifo_count_reg <= fifo_count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid) begin
            fifo_mem[wr_ptr_reg].meta <= div_meta;
            fifo_mem[wr_ptr_reg].avg  <= div_avg;
        end
    end

    assign head    = fifo_mem[rd_ptr_reg];
    assign m_tdata = {{M_PAD_W{1'b0}}, head.meta.out_row, head.meta.out_column, head.avg};
    assign m_tlast = head.meta.frame_done;

    `BAD_ASSERT_SAME(a_queue_room, aclk, aresetn, div_valid && !m_pop, fifo_count_reg < FIFO_CNT_W'(FIFO_DEPTH), "Result pushed into a full output queue.")
    `BAD_ASSERT_SAME(a_fwd_consumed, aclk, aresetn, fwd_valid_reg, p1_valid_reg, "Forwarded sums present with no beat in the accumulate stage.")
    `BAD_ASSERT_SAME(a_phase_range, aclk, aresetn, !rc_busy, CMP_W'(phase_reg) < CMP_W'(n_c), "Row phase out of range for the block edge.")
    `BAD_ASSERT_NEXT(a_cfg_holds_input, aclk, aresetn, cfg_wr_en, !s_tready, "Input ready while the geometry is being recalculated.")

endmodule
